>>> sv/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
// Used by sorted_priority_queue.sv; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spq: assertion failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spq: assertion failed");

`endif

>>> sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 16;
	localparam int ENTRIES_W = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} spq_cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4
	} spq_status_t;

	typedef struct packed {
		spq_cmd_t               cmd;
		logic [KEY_W-1:0]       key_in;
		logic [PAYLOAD_W-1:0]   payload_in;
	} spq_in_t;

	typedef struct packed {
		spq_status_t            status;
		logic [KEY_W-1:0]       key_out;
		logic [PAYLOAD_W-1:0]   payload_out;
		logic [ENTRIES_W-1:0]   entries;
	} spq_out_t;

	// one queue slot as it moves along the chain
	typedef struct packed {
		logic                   valid;
		logic [KEY_W-1:0]       key;
		logic [PAYLOAD_W-1:0]   payload;
	} spq_entry_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic cmp;   // latch compare flags against the incoming key
		logic push;  // insert: hold, take new entry, or shift up from below
		logic pop;   // shift down toward the head
	} spq_cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the incoming
// key and moves data to/from its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire spq_pkg::spq_cell_ctl_t     ctl,
	input  wire [spq_pkg::KEY_W-1:0]        cmp_key,
	input  wire spq_pkg::spq_entry_t        ins,
	input  wire spq_pkg::spq_entry_t        prev,
	input  wire                             prev_lt,
	input  wire spq_pkg::spq_entry_t        next,
	output spq_pkg::spq_entry_t             cur,
	output logic                            lt,
	output logic                            eq
);
	import spq_pkg::*;

	logic                 vld_q;
	logic [KEY_W-1:0]     key_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic                 lt_q;
	logic                 eq_q;
	spq_entry_t           cur_d;

	assign cur = '{valid: vld_q, key: key_q, payload: pay_q};
	assign lt  = lt_q;
	assign eq  = eq_q;

	// on push, smaller keys stay put; the first slot not smaller takes the new entry,
	// every slot above it takes its lower neighbor; on pop, every slot takes its upper neighbor
	always_comb begin
		cur_d = cur;
		if (ctl.push) begin
			if (!lt_q) begin
				cur_d = prev_lt ? ins : prev;
			end
		end else if (ctl.pop) begin
			cur_d = next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			lt_q  <= 1'b0;
			eq_q  <= 1'b0;
		end else begin
			vld_q <= cur_d.valid;
			if (ctl.cmp) begin
				lt_q <= vld_q && (key_q < cmp_key);
				eq_q <= vld_q && (key_q == cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= cur_d.key;
		pay_q <= cur_d.payload;
	end

endmodule

`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots plus the
// command/result control. Depends on spq_pkg, spq_cell and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_defines.svh"

// Usage:
//   A command beat (item: push or pop) is taken on a rising edge with start
//   high and busy low. Each command gives exactly one result beat on
//   'result', marked by 'done' for one cycle; the receiver cannot stall it.
//   The accepted command is registered in the s1 stage, and the result is
//   then registered into 'result'. A new command is not taken while one is
//   in s1: busy is high for the cycle after an accept.
//   First every cell compares its key with the incoming key and registers
//   its less-than / equal flags. Then the equal flags are OR-reduced for
//   the duplicate check, then all cells shift in parallel (push opens a gap
//   at the first slot whose key is not smaller; pop moves the chain toward
//   slot 0, which always holds the smallest key).
//   Duplicate keys are ignored even when full; a new key when full is
//   rejected. Pops on an empty queue report empty with zero key/payload.
//   Reset (arst_n low) empties the queue at once and drops any command in
//   flight; no result beat is produced for it.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  wire spq_pkg::spq_in_t  item,
	output logic                   done,
	output spq_pkg::spq_out_t      result
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                 accept;
	logic                 vld_s1;
	spq_cmd_t             cmd_s1;
	logic [KEY_W-1:0]     key_s1;
	logic [PAYLOAD_W-1:0] pay_s1;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic                 done_q;
	spq_out_t             result_q;
	spq_out_t             result_d;

	spq_cell_ctl_t        ctl;
	spq_entry_t           ins;
	spq_entry_t           ent [DEPTH];
	logic [DEPTH-1:0]     lt_vec;
	logic [DEPTH-1:0]     eq_vec;
	logic [DEPTH-1:0]     vld_vec;
	logic                 dup;
	logic                 full;
	logic                 has_head;
	logic                 pop_done;

	assign accept   = start && !busy;
	assign busy     = vld_s1;
	assign dup      = |eq_vec;
	assign full     = vld_vec[DEPTH-1];
	assign has_head = vld_vec[0];
	assign ins      = '{valid: 1'b1, key: key_s1, payload: pay_s1};

	assign ctl.cmp  = accept;
	assign ctl.push = vld_s1 && (cmd_s1 == CMD_PUSH) && !dup && !full;
	assign ctl.pop  = vld_s1 && (cmd_s1 == CMD_POP) && has_head;

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t prev_e;
		spq_entry_t next_e;
		logic       prev_lt;

		if (i == 0) begin : g_head
			assign prev_e  = '0;
			assign prev_lt = 1'b1;
		end else begin : g_body
			assign prev_e  = ent[i-1];
			assign prev_lt = lt_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_link
			assign next_e = ent[i+1];
		end

		spq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cmp_key (item.key_in),
			.ins     (ins),
			.prev    (prev_e),
			.prev_lt (prev_lt),
			.next    (next_e),
			.cur     (ent[i]),
			.lt      (lt_vec[i]),
			.eq      (eq_vec[i])
		);

		assign vld_vec[i] = ent[i].valid;
	end

	always_comb begin
		count_d = count_q;
		if (ctl.push) begin
			count_d = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		result_d             = '0;
		result_d.entries     = ENTRIES_W'(count_d);
		if (cmd_s1 == CMD_POP) begin
			if (has_head) begin
				result_d.status      = ST_POPPED;
				result_d.key_out     = ent[0].key;
				result_d.payload_out = ent[0].payload;
			end else begin
				result_d.status      = ST_EMPTY;
			end
		end else if (dup) begin
			result_d.status = ST_DUPLICATE;
		end else if (full) begin
			result_d.status = ST_FULL;
		end else begin
			result_d.status = ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			vld_s1  <= accept;
			done_q  <= vld_s1;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= item.cmd;
			key_s1 <= item.key_in;
			pay_s1 <= item.payload_in;
		end
		if (vld_s1) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	assign pop_done = done && (result.status == ST_POPPED);

	// every accepted command yields a result beat, flagged by done after its s1 stage
	`SPQ_ASSERT_NEXT(a_result_follows, clk, arst_n, vld_s1, done)
	// occupied slots form a contiguous run from the head
	`SPQ_ASSERT_NOW(a_thermometer, clk, arst_n, 1'b1, ((vld_vec >> 1) & ~vld_vec) == '0)
	// the count tracks the occupied slots
	`SPQ_ASSERT_NOW(a_count_match, clk, arst_n, 1'b1, count_q == CW'($countones(vld_vec)))
	// a pop result implies the count fell by one
	`SPQ_ASSERT_NOW(a_pop_count, clk, arst_n, pop_done, count_q == $past(count_q) - CW'(1))

endmodule

`default_nettype wire
